// ----- src/nsc_pkg.sv -----
package nsc_pkg;

  // pattern storage
  localparam int PATTERN_MAX    = 16;
  localparam int CHAR_BITS      = 16;
  localparam int CHARS_PER_WORD = 4;
  localparam int WORD_COUNT     = 4;
  localparam int WORD_BITS      = CHAR_BITS * CHARS_PER_WORD;

  // length and index widths
  localparam int PLEN_BITS = 5;
  localparam int LEN_BITS  = $clog2(PATTERN_MAX + 1);
  localparam int IDX_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // match counter
  localparam int COUNT_BITS = 32;
  localparam int OUT_BITS   = 32;

  // configuration port
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;

  typedef logic [CHAR_BITS-1:0] char_t;

  // control handed to every cell
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- src/nsc_cell.sv -----
module nsc_cell (
  input  logic                clk,
  input  logic                rst,
  input  nsc_pkg::cell_ctrl_t ctrl,
  input  nsc_pkg::char_t      text_chr,
  input  nsc_pkg::char_t      pat_chr,
  input  logic                prev_flag,
  output logic                flag,
  output logic                flag_next
);

  // prefix up to this cell matches ending at the current char
  assign flag_next = prev_flag & (text_chr == pat_chr);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.advance) begin
      if (ctrl.clear) begin
        flag <= 1'b0;
      end else begin
        flag <= flag_next;
      end
    end
  end

endmodule

// ----- src/nonoverlap_substring_counter_unit.sv -----
// non-overlapping substring counter
// the count of a text is registered on its last beat and valid in the next cycle
// throughput: one character per cycle, one row of cells; an unread count stalls it
// reset: synchronous rst clears the pattern registers, match cells, holdoff and count
// the stream state clears again after every last character
module nonoverlap_substring_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // character channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [nsc_pkg::CHAR_BITS-1:0]        text_char,
  input  logic                                 end_of_text,
  // count channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nsc_pkg::OUT_BITS-1:0]         occurrence_count,
  // configuration writes
  input  logic                                 cfg_write,
  input  logic [nsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [nsc_pkg::WORD_BITS-1:0]        cfg_data
);

  localparam int PMAX = nsc_pkg::PATTERN_MAX;

  // configuration registers
  logic [nsc_pkg::PLEN_BITS-1:0] pattern_length;
  logic [nsc_pkg::WORD_BITS-1:0] pattern_word [nsc_pkg::WORD_COUNT];

  // stream state
  logic [nsc_pkg::LEN_BITS-1:0]   holdoff_left;
  logic [nsc_pkg::COUNT_BITS-1:0] match_total;

  logic [nsc_pkg::LEN_BITS-1:0]   holdoff_next;
  logic [nsc_pkg::COUNT_BITS-1:0] total_next;
  logic [nsc_pkg::OUT_BITS-1:0]   count_out;

  logic                          accept;
  logic [nsc_pkg::LEN_BITS-1:0]  len_eff;
  logic [nsc_pkg::LEN_BITS-1:0]  len_less1;
  logic                          hit;
  nsc_pkg::cell_ctrl_t           ctrl;

  logic [PMAX-1:0] flag;
  logic [PMAX-1:0] flag_next;

  // a beat is taken whenever the count register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl.advance = accept;
  assign ctrl.clear   = end_of_text;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int w = 0; w < nsc_pkg::WORD_COUNT; w++) begin
        pattern_word[w] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        nsc_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[nsc_pkg::PLEN_BITS-1:0];
        nsc_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        nsc_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        nsc_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        nsc_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;  // indexes past the last register are dropped
      endcase
    end
  end

  // overlong pattern length clamps to the number of cells
  always_comb begin
    if (pattern_length > nsc_pkg::PLEN_BITS'(PMAX)) begin
      len_eff = nsc_pkg::LEN_BITS'(PMAX);
    end else begin
      len_eff = pattern_length[nsc_pkg::LEN_BITS-1:0];
    end
  end

  assign len_less1 = len_eff - nsc_pkg::LEN_BITS'(1);

  // ---------------------------------------------------------------------
  // row of match cells
  // cell k holds pattern char k and a flag meaning the first k+1 pattern
  // chars matched ending at the latest char; each accepted char moves a flag
  // one cell along, so a flag at cell len-1 marks a full match ending here
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < PMAX; k++) begin : g_cell
    localparam int W = k / nsc_pkg::CHARS_PER_WORD;
    localparam int S = (k % nsc_pkg::CHARS_PER_WORD) * nsc_pkg::CHAR_BITS;

    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = flag[k-1];
    end

    nsc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .text_chr  (text_char),
      .pat_chr   (pattern_word[W][S +: nsc_pkg::CHAR_BITS]),
      .prev_flag (prev),
      .flag      (flag[k]),
      .flag_next (flag_next[k])
    );
  end

  // ---------------------------------------------------------------------
  // counting with holdoff: a match counts only when the previous counted
  // match has fully passed, which gives leftmost non-overlapping matches
  // ---------------------------------------------------------------------
  always_comb begin
    hit = (len_eff != '0) && (holdoff_left == '0) &&
          flag_next[len_less1[nsc_pkg::IDX_BITS-1:0]];

    if (holdoff_left != '0) begin
      holdoff_next = holdoff_left - nsc_pkg::LEN_BITS'(1);
    end else if (hit) begin
      holdoff_next = len_less1;
    end else begin
      holdoff_next = '0;
    end

    // count saturates at all ones
    if (hit && (match_total != '1)) begin
      total_next = match_total + nsc_pkg::COUNT_BITS'(1);
    end else begin
      total_next = match_total;
    end

    // emitted value saturates at the output width
    if (64'(total_next) > 64'(nsc_pkg::OUT_BITS'('1))) begin
      count_out = '1;
    end else begin
      count_out = nsc_pkg::OUT_BITS'(total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_left <= '0;
      match_total  <= '0;
    end else if (accept) begin
      if (end_of_text) begin
        holdoff_left <= '0;
        match_total  <= '0;
      end else begin
        holdoff_left <= holdoff_next;
        match_total  <= total_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register: loaded on the last character beat of a text
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_text) begin
      occurrence_count <= count_out;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;

  // longest stretch the receiver is held off on purpose
  localparam int LONG_HOLD = 300;
  // cycles without any beat or register write before the run is called dead
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    nsc_pkg::char_t ch;
    logic           last;
  } char_beat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [nsc_pkg::CHAR_BITS-1:0]    text_char = '0;
  logic                             end_of_text = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [nsc_pkg::OUT_BITS-1:0]     occurrence_count;
  logic                             cfg_write = 1'b0;
  logic [nsc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [nsc_pkg::WORD_BITS-1:0]    cfg_data = '0;

  // mirror of the pattern registers
  logic [nsc_pkg::PLEN_BITS-1:0] pat_len = '0;
  logic [nsc_pkg::WORD_BITS-1:0] pat_word [nsc_pkg::WORD_COUNT] = '{default: '0};

  // stream state tracked alongside the block
  nsc_pkg::char_t                 recent [nsc_pkg::PATTERN_MAX] = '{default: '0};
  logic [nsc_pkg::LEN_BITS-1:0]   chars_so_far = '0;
  logic [nsc_pkg::LEN_BITS-1:0]   blocked_left = '0;
  logic [nsc_pkg::COUNT_BITS-1:0] matches_so_far = '0;

  char_beat_t                   pending_chars [$];
  logic [nsc_pkg::OUT_BITS-1:0] expected_counts [$];
  int                           chars_in_flight = 0;
  int                           mismatches = 0;

  // idling knobs, changed only between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // letters the pattern and most of the text are drawn from
  nsc_pkg::char_t letters [3];

  nonoverlap_substring_counter_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .text_char        (text_char),
    .end_of_text      (end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .occurrence_count (occurrence_count),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pattern character k from the register mirror, character 0 lowest
  function automatic nsc_pkg::char_t pattern_at(input int k);
    return pat_word[k / nsc_pkg::CHARS_PER_WORD]
                   [(k % nsc_pkg::CHARS_PER_WORD) * nsc_pkg::CHAR_BITS +: nsc_pkg::CHAR_BITS];
  endfunction

  // advance the tracked stream by one character; returns 1 when a count is due
  function automatic bit track_char(input nsc_pkg::char_t ch, input logic last,
                                    output logic [nsc_pkg::OUT_BITS-1:0] total);
    int len;
    bit hit;
    len = (pat_len > nsc_pkg::PATTERN_MAX) ? nsc_pkg::PATTERN_MAX : pat_len;
    for (int i = nsc_pkg::PATTERN_MAX - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = ch;
    if (chars_so_far < nsc_pkg::PATTERN_MAX) chars_so_far++;
    // a counted match blocks the next len-1 characters from starting another
    if (blocked_left != 0) begin
      blocked_left--;
    end else if (len != 0 && chars_so_far >= len) begin
      hit = 1'b1;
      // oldest character in the window lines up with pattern character 0
      for (int k = 0; k < len; k++) begin
        if (pattern_at(k) != recent[len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        if (matches_so_far != '1) matches_so_far++;
        blocked_left = nsc_pkg::LEN_BITS'(len - 1);
      end
    end
    total = '0;
    if (last) begin
      // the emitted count saturates at the output width
      total = (64'(matches_so_far) > 64'({nsc_pkg::OUT_BITS{1'b1}})) ?
              '1 : nsc_pkg::OUT_BITS'(matches_so_far);
      recent = '{default: '0};
      chars_so_far = '0;
      blocked_left = '0;
      matches_so_far = '0;
    end
    return last;
  endfunction

  // character driver: valid holds with a stable payload until the beat is taken
  always @(posedge clk) begin : char_driver
    char_beat_t nxt;
    logic [nsc_pkg::OUT_BITS-1:0] cnt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        chars_in_flight--;
        if (track_char(text_char, end_of_text, cnt)) expected_counts.push_back(cnt);
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          in_valid    <= 1'b1;
          text_char   <= nxt.ch;
          end_of_text <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // count monitor and receiver back-pressure
  always @(posedge clk) begin : count_monitor
    logic [nsc_pkg::OUT_BITS-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: occurrence_count expected none actual %0d", $time, occurrence_count);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (occurrence_count !== want) begin
            $display("%0t: occurrence_count expected %0d actual %0d",
                     $time, want, occurrence_count);
            mismatches++;
          end
        end
      end
      // long hold-off: a count waits in the block's output register and the block stops taking characters
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no progress at all
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one register write, mirror updated as the write is driven
  task automatic write_reg(input logic [nsc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [nsc_pkg::WORD_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == nsc_pkg::REG_PATTERN_LENGTH) begin
      pat_len = data[nsc_pkg::PLEN_BITS-1:0];
    end else if (idx >= nsc_pkg::REG_PATTERN_WORD_0 && idx <= nsc_pkg::REG_PATTERN_WORD_3) begin
      pat_word[idx - nsc_pkg::REG_PATTERN_WORD_0] = data;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_text(input nsc_pkg::char_t text [$]);
    char_beat_t b;
    for (int i = 0; i < text.size(); i++) begin
      b.ch = text[i];
      b.last = (i == text.size() - 1);
      pending_chars.push_back(b);
      chars_in_flight++;
    end
  endtask

  task automatic wait_drained();
    while (chars_in_flight != 0 || expected_counts.size() != 0) @(posedge clk);
  endtask

  // drained, plus room for a character that causes no count to finish
  task automatic wait_idle();
    wait_drained();
    repeat (3) @(posedge clk);
  endtask

  // new pattern drawn from two random letters; unused slots hold junk
  task automatic load_pattern(input int len_value);
    logic [nsc_pkg::WORD_BITS-1:0] w;
    int eff;
    int k;
    eff = (len_value > nsc_pkg::PATTERN_MAX) ? nsc_pkg::PATTERN_MAX : len_value;
    for (int i = 0; i < 3; i++) letters[i] = nsc_pkg::char_t'($urandom);
    w = {$urandom, $urandom};
    w[nsc_pkg::PLEN_BITS-1:0] = nsc_pkg::PLEN_BITS'(len_value);
    write_reg(nsc_pkg::REG_PATTERN_LENGTH, w);
    for (int wi = 0; wi < nsc_pkg::WORD_COUNT; wi++) begin
      w = {$urandom, $urandom};
      for (int c = 0; c < nsc_pkg::CHARS_PER_WORD; c++) begin
        k = wi * nsc_pkg::CHARS_PER_WORD + c;
        if (k < eff) w[c*nsc_pkg::CHAR_BITS +: nsc_pkg::CHAR_BITS] = letters[$urandom_range(1)];
      end
      write_reg(nsc_pkg::CFG_IDX_BITS'(nsc_pkg::REG_PATTERN_WORD_0 + wi), w);
    end
  endtask

  // texts of whole patterns, broken prefixes, letters and random noise
  task automatic queue_texts(input int budget, input int max_len);
    nsc_pkg::char_t text [$];
    int used, want_len, eff, r, part;
    eff = (pat_len > nsc_pkg::PATTERN_MAX) ? nsc_pkg::PATTERN_MAX : pat_len;
    used = 0;
    while (used < budget) begin
      text.delete();
      want_len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 3 * max_len)
                                          : $urandom_range(1, max_len);
      while (text.size() < want_len) begin
        r = $urandom_range(99);
        part = 0;
        if (eff != 0 && r < 35) part = eff;
        else if (eff > 1 && r < 45) part = $urandom_range(1, eff - 1);
        if (part != 0) begin
          for (int k = 0; k < part; k++) text.push_back(pattern_at(k));
        end else if (r < 85) begin
          text.push_back(letters[$urandom_range(2)]);
        end else begin
          text.push_back(nsc_pkg::char_t'($urandom));
        end
      end
      push_text(text);
      used += text.size();
    end
  endtask

  initial begin : stimulus
    nsc_pkg::char_t text [$];
    logic [nsc_pkg::WORD_BITS-1:0] w;
    int phase_lens [8];
    phase_lens = '{1, 2, 3, 16, 31, 0, 5, 17};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty pattern straight out of reset: count stays zero
    text = {16'h0000, 16'hFFFF};
    push_text(text);
    wait_idle();

    // two-letter pattern on a run of that letter: overlaps must not count
    w = {$urandom, $urandom};
    w[nsc_pkg::PLEN_BITS-1:0] = nsc_pkg::PLEN_BITS'(2);
    write_reg(nsc_pkg::REG_PATTERN_LENGTH, w);
    write_reg(nsc_pkg::REG_PATTERN_WORD_0, {$urandom, 16'h8001, 16'h8001});
    // indexes past the last register are ignored
    for (int r = nsc_pkg::REG_PATTERN_WORD_3 + 1; r < (1 << nsc_pkg::CFG_IDX_BITS); r++) begin
      write_reg(nsc_pkg::CFG_IDX_BITS'(r), '1);
    end
    text = {16'h8001, 16'h8001, 16'h8001, 16'h8001, 16'h8001};
    push_text(text);
    wait_idle();

    // text shorter than the pattern
    text = {16'h8001};
    push_text(text);
    wait_idle();

    // overlong length acts as a full-width pattern; text is exactly the pattern
    w = {$urandom, $urandom};
    w[nsc_pkg::PLEN_BITS-1:0] = nsc_pkg::PLEN_BITS'(nsc_pkg::PATTERN_MAX + 1);
    write_reg(nsc_pkg::REG_PATTERN_LENGTH, w);
    write_reg(nsc_pkg::REG_PATTERN_WORD_0, {$urandom, $urandom});
    write_reg(nsc_pkg::REG_PATTERN_WORD_1, {$urandom, $urandom});
    write_reg(nsc_pkg::REG_PATTERN_WORD_2, {$urandom, $urandom});
    write_reg(nsc_pkg::REG_PATTERN_WORD_3, {$urandom, $urandom});
    text.delete();
    for (int k = 0; k < nsc_pkg::PATTERN_MAX; k++) text.push_back(pattern_at(k));
    push_text(text);
    wait_idle();

    // random phases, cycling through the idling modes
    for (int p = 0; p < 8; p++) begin
      load_pattern(phase_lens[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      if (p == 4) begin
        // short texts under a held-off receiver fill the block
        hold_request = 1'b1;
        queue_texts(60, 3);
        queue_texts(40, 20);
      end else if (p == 1) begin
        // sender stops until every count is back, then resumes
        queue_texts(50, 20);
        wait_drained();
        queue_texts(50, 20);
      end else begin
        queue_texts(100, 20);
      end
      wait_idle();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nsc_pkg.sv
src/nsc_cell.sv
src/nonoverlap_substring_counter_unit.sv
tb/sv/tb.sv
